>>> sv/ps2md_pkg.sv
// Shared types, codes and helper functions of the PS/2 mouse packet decoder.
package ps2md_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned SetW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // input item codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WHEEL_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_W   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_H   = 2'd2;

  // reset values of the configuration registers
  localparam logic [SizeW-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SizeW-1:0] SCREEN_H_RST = 13'd480;

  // button codes of a result item
  localparam logic [2:0] BTN_LEFT     = 3'd1;
  localparam logic [2:0] BTN_MIDDLE   = 3'd2;
  localparam logic [2:0] BTN_RIGHT    = 3'd3;
  localparam logic [2:0] BTN_WHEEL_UP = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DN = 3'd5;

  // status byte fields
  localparam int unsigned STAT_XSIGN = 4;
  localparam int unsigned STAT_YSIGN = 5;
  localparam logic [7:0]  WHEEL_DN_MIN = 8'd127;

  // byte positions within a packet
  localparam logic [1:0] IDX_STATUS = 2'd0;
  localparam logic [1:0] IDX_DX     = 2'd1;
  localparam logic [1:0] IDX_DY     = 2'd2;
  localparam logic [1:0] IDX_WHEEL  = 2'd3;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]        byte_index;
    logic [7:0]        status_byte;
    logic [7:0]        delta_x_byte;
    logic [7:0]        delta_y_byte;
    logic [2:0]        button_bits;
    logic [CoordW-1:0] cursor_x;
    logic [CoordW-1:0] cursor_y;
  } dec_state_t;

  // events of one finished packet; pend bits in output order:
  // [0] wheel, [1] left, [2] right, [3] middle
  typedef struct packed {
    logic       finish;
    logic [3:0] pend;
    logic       wheel_dn;
    logic [2:0] rel;
  } evt_t;

  // largest cursor value for a screen size
  function automatic logic [CoordW-1:0] limit_of(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] dec;
    dec = size - 13'd1;
    if (size == '0) begin
      limit_of = '0;
    end else if (size[SizeW-1] && (size[SizeW-2:0] != '0)) begin
      limit_of = '1;
    end else begin
      limit_of = dec[CoordW-1:0];
    end
  endfunction

  // clamp a signed coordinate into [0, hi]
  function automatic logic [CoordW-1:0] clamp_to(input logic signed [16:0] v,
                                                 input logic [CoordW-1:0] hi);
    logic signed [16:0] hi_s;
    hi_s = $signed({5'b0, hi});
    if (v < 0) begin
      clamp_to = '0;
    end else if (v > hi_s) begin
      clamp_to = hi;
    end else begin
      clamp_to = v[CoordW-1:0];
    end
  endfunction

endpackage

>>> sv/ps2_mouse_packet_decoder.sv
// Top level: PS/2 / wheel mouse packet decoder with cursor and event queue.
//
//   port group | direction | handshake           | carries
//   in_*       | input     | in_valid/in_ready   | command, rx_byte, set_x, set_y
//   out_*      | output    | out_valid/out_ready | release_res, button, pos_x, pos_y, last
//   cfg_*      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A byte or set command is decoded in the cycle it is transferred; the state
// registers feed the decode logic and its events land in the output register.
// A packet with k events holds the output until all k have gone out,
// one event per cycle while out_ready stays high; a low out_ready stalls the output and the input.
// The next item is taken in the same cycle as the packet's last event.
// Reset is synchronous; configuration writes are always taken.
module ps2_mouse_packet_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [7:0]                         in_rx_byte,
  input  logic signed [ps2md_pkg::SetW-1:0]  in_set_x,
  input  logic signed [ps2md_pkg::SetW-1:0]  in_set_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_release_res,
  output logic [2:0]                         out_button,
  output logic [ps2md_pkg::CoordW-1:0]       out_pos_x,
  output logic [ps2md_pkg::CoordW-1:0]       out_pos_y,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ps2md_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ps2md_pkg::SizeW-1:0]        cfg_data
);

  logic                         wheel_mode_r;
  logic [ps2md_pkg::SizeW-1:0]  screen_w_r;
  logic [ps2md_pkg::SizeW-1:0]  screen_h_r;
  ps2md_pkg::dec_state_t        st_r;
  ps2md_pkg::dec_state_t        st_nxt;
  ps2md_pkg::evt_t              evt;
  logic [3:0]                   pend_r;
  logic [3:0]                   pend_nxt;
  logic                         wheel_dn_r;
  logic [2:0]                   rel_r;
  logic [ps2md_pkg::CoordW-1:0] pos_x_r;
  logic [ps2md_pkg::CoordW-1:0] pos_y_r;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      screen_w_r   <= ps2md_pkg::SCREEN_W_RST;
      screen_h_r   <= ps2md_pkg::SCREEN_H_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        ps2md_pkg::CFG_WHEEL_MODE: wheel_mode_r <= cfg_data[0];
        ps2md_pkg::CFG_SCREEN_W:   screen_w_r   <= cfg_data;
        ps2md_pkg::CFG_SCREEN_H:   screen_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  ps2md_step u_step (
    .st            (st_r),
    .wheel_mode    (wheel_mode_r),
    .screen_width  (screen_w_r),
    .screen_height (screen_h_r),
    .command       (in_command),
    .rx_byte       (in_rx_byte),
    .set_x         (in_set_x),
    .set_y         (in_set_y),
    .st_nxt        (st_nxt),
    .evt           (evt)
  );

  // output side: lowest pending bit is the current event
  assign out_valid = (pend_r != 4'd0);
  assign out_last  = ((pend_r & (pend_r - 4'd1)) == 4'd0);
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = !out_valid || (out_ready && out_last);
  assign in_xfer   = in_valid && in_ready;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;

  always_comb begin
    if (pend_r[0]) begin
      out_release_res = 1'b0;
      out_button      = wheel_dn_r ? ps2md_pkg::BTN_WHEEL_DN : ps2md_pkg::BTN_WHEEL_UP;
    end else if (pend_r[1]) begin
      out_release_res = rel_r[0];
      out_button      = ps2md_pkg::BTN_LEFT;
    end else if (pend_r[2]) begin
      out_release_res = rel_r[1];
      out_button      = ps2md_pkg::BTN_RIGHT;
    end else begin
      out_release_res = rel_r[2];
      out_button      = ps2md_pkg::BTN_MIDDLE;
    end
  end

  // drop the delivered event, or load a finished packet's events
  always_comb begin
    pend_nxt = pend_r;
    if (out_xfer) begin
      pend_nxt = pend_r & (pend_r - 4'd1);
    end
    if (in_xfer && evt.finish) begin
      pend_nxt = evt.pend;
    end
  end

  // control state: decoder state and pending events
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (in_xfer) begin
        st_r <= st_nxt;
      end
    end
  end

  // hold event payload of the finished packet
  always_ff @(posedge clk) begin
    if (in_xfer && evt.finish) begin
      wheel_dn_r <= evt.wheel_dn;
      rel_r      <= evt.rel;
      pos_x_r    <= st_nxt.cursor_x;
      pos_y_r    <= st_nxt.cursor_y;
    end
  end

  // a wheel event never shares a packet with button events
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[0] |-> (pend_r[3:1] == 3'd0))
    else $error("wheel event queued with button events");

  // shown button codes stay within the defined set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_button >= ps2md_pkg::BTN_LEFT && out_button <= ps2md_pkg::BTN_WHEEL_DN))
    else $error("undefined button code on output");

  // position holds while a packet's events are still going out
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(out_ready && out_last)) |=> ($stable(out_pos_x) && $stable(out_pos_y)))
    else $error("position changed mid packet");

  // queue drains after the last event when nothing new finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last && !(in_xfer && evt.finish)) |=> !out_valid)
    else $error("event left after last transfer");

  // no item taken while more than one event waits
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!out_valid || (out_xfer && $countones(pend_r) == 1)))
    else $error("item taken with events still pending");

endmodule

>>> sv/ps2md_step.sv
// Next-state and event logic for one accepted mouse byte or set command.
module ps2md_step (
  input  ps2md_pkg::dec_state_t             st,
  input  logic                              wheel_mode,
  input  logic [ps2md_pkg::SizeW-1:0]       screen_width,
  input  logic [ps2md_pkg::SizeW-1:0]       screen_height,
  input  logic                              command,
  input  logic [7:0]                        rx_byte,
  input  logic signed [ps2md_pkg::SetW-1:0] set_x,
  input  logic signed [ps2md_pkg::SetW-1:0] set_y,
  output ps2md_pkg::dec_state_t             st_nxt,
  output ps2md_pkg::evt_t                   evt
);

  logic [ps2md_pkg::CoordW-1:0] lim_x;
  logic [ps2md_pkg::CoordW-1:0] lim_y;
  logic [7:0]                   dy_eff;
  logic [7:0]                   wheel_byte;
  logic signed [8:0]            dx_s;
  logic signed [8:0]            dy_s;
  logic signed [16:0]           x_sum;
  logic signed [16:0]           y_sum;
  logic [2:0]                   now_btn;
  logic [2:0]                   diff;

  assign lim_x = ps2md_pkg::limit_of(screen_width);
  assign lim_y = ps2md_pkg::limit_of(screen_height);

  // the finishing byte itself may be the delta y or the wheel byte
  assign dy_eff     = (st.byte_index == ps2md_pkg::IDX_DY) ? rx_byte : st.delta_y_byte;
  assign wheel_byte = (st.byte_index == ps2md_pkg::IDX_WHEEL) ? rx_byte : 8'd0;

  // sign-extended motion, x moves up and y moves down
  assign dx_s  = $signed({st.status_byte[ps2md_pkg::STAT_XSIGN], st.delta_x_byte});
  assign dy_s  = $signed({st.status_byte[ps2md_pkg::STAT_YSIGN], dy_eff});
  assign x_sum = $signed({5'b0, st.cursor_x}) + 17'(dx_s);
  assign y_sum = $signed({5'b0, st.cursor_y}) - 17'(dy_s);

  assign now_btn = st.status_byte[2:0];
  assign diff    = st.button_bits ^ now_btn;

  always_comb begin
    st_nxt       = st;
    evt          = '0;
    evt.rel      = st.button_bits;
    if (command == ps2md_pkg::CMD_SET) begin
      // load the cursor directly; byte assembly untouched
      st_nxt.cursor_x = ps2md_pkg::clamp_to(17'(set_x), lim_x);
      st_nxt.cursor_y = ps2md_pkg::clamp_to(17'(set_y), lim_y);
    end else begin
      case (st.byte_index)
        ps2md_pkg::IDX_STATUS: begin
          st_nxt.status_byte = rx_byte;
          st_nxt.byte_index  = ps2md_pkg::IDX_DX;
        end
        ps2md_pkg::IDX_DX: begin
          st_nxt.delta_x_byte = rx_byte;
          st_nxt.byte_index   = ps2md_pkg::IDX_DY;
        end
        ps2md_pkg::IDX_DY: begin
          st_nxt.delta_y_byte = rx_byte;
          if (wheel_mode) begin
            st_nxt.byte_index = ps2md_pkg::IDX_WHEEL;
          end else begin
            st_nxt.byte_index = ps2md_pkg::IDX_STATUS;
            evt.finish        = 1'b1;
          end
        end
        default: begin
          st_nxt.byte_index = ps2md_pkg::IDX_STATUS;
          evt.finish        = 1'b1;
        end
      endcase

      // finish the packet: wheel event, or motion plus button changes
      if (evt.finish) begin
        if (wheel_byte != 8'd0) begin
          evt.pend     = 4'b0001;
          evt.wheel_dn = (wheel_byte >= ps2md_pkg::WHEEL_DN_MIN);
        end else begin
          if ((st.delta_x_byte != 8'd0) || (dy_eff != 8'd0)) begin
            st_nxt.cursor_x = ps2md_pkg::clamp_to(x_sum, lim_x);
            st_nxt.cursor_y = ps2md_pkg::clamp_to(y_sum, lim_y);
          end
          evt.pend           = {diff[2], diff[1], diff[0], 1'b0};
          st_nxt.button_bits = now_btn;
        end
      end
    end
  end

endmodule
